FILE: hdl/rational_alu_gcd_reduce_macros.svh
// Assertion macros for the rational ALU.
`ifndef RATIONAL_ALU_GCD_REDUCE_MACROS_SVH
`define RATIONAL_ALU_GCD_REDUCE_MACROS_SVH

`ifndef SYNTHESIS
`define RAG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RAG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RAG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RAG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/rag_pkg.sv
package rag_pkg;

    localparam int NUM_OUT_WIDTH = 33;
    localparam int DEN_OUT_WIDTH = 31;
    localparam int REQ_WIDTH     = 2;
    localparam int STATUS_WIDTH  = 2;
    localparam int OUT_TDATA_W   = ((NUM_OUT_WIDTH + DEN_OUT_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_INDET = 2'd1,
        ST_UNDEF = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MUL_P0,
        MUL_P1,
        MUL_DEN
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_CLASS,
        S_GCD,
        S_DIVN_LD,
        S_DIVN,
        S_DIVD_LD,
        S_DIVD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     comb;
        logic     gcd_init;
        logic     gcd_step;
        logic     div_load;
        logic     div_den;
        logic     div_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic num_zero;
        logic den_zero;
        logic gcd_done;
        logic div_last;
        logic out_busy;
    } sts_t;

endpackage

FILE: hdl/rag_ctrl.sv
module rag_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  rag_pkg::sts_t sts,
    output rag_pkg::cmd_t cmd
);
    import rag_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P0;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P1;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DEN;
                state_next  = S_COMB;
            end
            S_COMB:
            begin
                cmd.comb   = 1'b1;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                cmd.gcd_init = 1'b1;
                // zero on either side needs no reduction
                if (sts.num_zero || sts.den_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    state_next = S_DIVN_LD;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN_LD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIVN;
            end
            S_DIVN:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DIVD_LD;
                end
            end
            S_DIVD_LD:
            begin
                cmd.div_load = 1'b1;
                cmd.div_den  = 1'b1;
                state_next   = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/rag_dp.sv
module rag_dp
#(
    parameter  int OPERAND_WIDTH = 16,
    localparam int IN_TDATA_W    = ((4 * OPERAND_WIDTH + 7) / 8) * 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [IN_TDATA_W-1:0]               s_tdata,
    input  logic [rag_pkg::REQ_WIDTH-1:0]       s_tuser,
    input  rag_pkg::cmd_t                       cmd,
    output rag_pkg::sts_t                       sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rag_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [rag_pkg::STATUS_WIDTH-1:0]    m_tuser
);
    import rag_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int MW = 2 * W + 1;
    localparam int KW = $clog2(MW);
    localparam int CW = $clog2(MW);
    localparam int XW = (MW > NUM_OUT_WIDTH) ? MW : NUM_OUT_WIDTH;

    localparam int A_NUM = 0;
    localparam int A_DEN = 1;
    localparam int B_NUM = 2;
    localparam int B_DEN = 3;

    // operand magnitudes and signs
    op_t            op_reg;
    logic [W-1:0]   opd_mag_reg [4];
    logic           opd_neg_reg [4];
    logic [W-1:0]   opd_mag_in  [4];
    logic           opd_neg_in  [4];

    logic [PW-1:0]  p0_mag_reg;
    logic           p0_neg_reg;
    logic [PW-1:0]  p1_mag_reg;
    logic           p1_neg_reg;
    logic [PW-1:0]  den_mag_reg;
    logic           den_neg_reg;
    logic [MW-1:0]  num_mag_reg;
    logic           num_neg_reg;

    logic [MW-1:0]  gx_reg;
    logic [MW-1:0]  gy_reg;
    logic [KW-1:0]  gk_reg;

    logic [MW-1:0]  dvs_reg;
    logic [MW-1:0]  rem_reg;
    logic [MW-1:0]  quo_reg;
    logic [MW-1:0]  qn_reg;
    logic [CW-1:0]  cnt_reg;

    logic                      out_valid_reg;
    logic [NUM_OUT_WIDTH-1:0]  res_num_reg;
    logic [DEN_OUT_WIDTH-1:0]  res_den_reg;
    status_t                   res_st_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            opd_neg_in[i] = s_tdata[i*W + W - 1];
            opd_mag_in[i] = opd_neg_in[i] ? (W'(0) - s_tdata[i*W +: W]) : s_tdata[i*W +: W];
        end
    end

    // shared multiplier, one product per cycle
    logic [1:0]    mx_idx;
    logic [1:0]    my_idx;
    logic [PW-1:0] prod;
    logic          prod_neg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_P0:
            begin
                mx_idx = 2'(A_NUM);
                my_idx = (op_reg == OP_MUL) ? 2'(B_NUM) : 2'(B_DEN);
            end
            MUL_P1:
            begin
                mx_idx = 2'(B_NUM);
                my_idx = 2'(A_DEN);
            end
            MUL_DEN:
            begin
                mx_idx = 2'(A_DEN);
                my_idx = (op_reg == OP_DIV) ? 2'(B_NUM) : 2'(B_DEN);
            end
            default:
            begin
                mx_idx = 2'(A_NUM);
                my_idx = 2'(B_NUM);
            end
        endcase
        prod     = PW'(opd_mag_reg[mx_idx]) * PW'(opd_mag_reg[my_idx]);
        prod_neg = (prod != '0) && (opd_neg_reg[mx_idx] != opd_neg_reg[my_idx]);
    end

    // signed-magnitude add (or subtract) of the two cross products; mul and div pass p0 through
    logic [MW-1:0] sx;
    logic [MW-1:0] sy;
    logic          sy_neg;
    logic [MW-1:0] sum_mag;
    logic          sum_neg;

    always_comb
    begin
        sx = MW'(p0_mag_reg);
        unique case (op_reg)
            OP_ADD:
            begin
                sy     = MW'(p1_mag_reg);
                sy_neg = p1_neg_reg;
            end
            OP_SUB:
            begin
                sy     = MW'(p1_mag_reg);
                sy_neg = (p1_mag_reg != '0) && !p1_neg_reg;
            end
            default:
            begin
                sy     = '0;
                sy_neg = 1'b0;
            end
        endcase
        if (p0_neg_reg == sy_neg)
        begin
            sum_mag = sx + sy;
            sum_neg = p0_neg_reg;
        end
        else if (sx >= sy)
        begin
            sum_mag = sx - sy;
            sum_neg = p0_neg_reg;
        end
        else
        begin
            sum_mag = sy - sx;
            sum_neg = sy_neg;
        end
        if (sum_mag == '0)
        begin
            sum_neg = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op_t'(s_tuser);
            for (int i = 0; i < 4; i++)
            begin
                opd_mag_reg[i] <= opd_mag_in[i];
                opd_neg_reg[i] <= opd_neg_in[i];
            end
        end
        if (cmd.mul_en)
        begin
            unique case (cmd.mul_sel)
                MUL_P0:
                begin
                    p0_mag_reg <= prod;
                    p0_neg_reg <= prod_neg;
                end
                MUL_P1:
                begin
                    p1_mag_reg <= prod;
                    p1_neg_reg <= prod_neg;
                end
                default:
                begin
                    den_mag_reg <= prod;
                    den_neg_reg <= prod_neg;
                end
            endcase
        end
        if (cmd.comb)
        begin
            num_mag_reg <= sum_mag;
            num_neg_reg <= sum_neg;
        end
    end

    // binary GCD: one shift or subtract-and-shift per cycle, done when x == y
    logic [MW-1:0] gdiff_xy;
    logic [MW-1:0] gdiff_yx;

    assign gdiff_xy = gx_reg - gy_reg;
    assign gdiff_yx = gy_reg - gx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.gcd_init)
        begin
            gx_reg <= num_mag_reg;
            gy_reg <= MW'(den_mag_reg);
            gk_reg <= '0;
        end
        else if (cmd.gcd_step)
        begin
            priority if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + 1'b1;
            end
            else if (!gx_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
            end
            else if (!gy_reg[0])
            begin
                gy_reg <= gy_reg >> 1;
            end
            else if (gx_reg > gy_reg)
            begin
                gx_reg <= gdiff_xy >> 1;
            end
            else
            begin
                gy_reg <= gdiff_yx >> 1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [MW:0] div_sh;
    logic [MW:0] div_trial;
    logic        div_fit;

    assign div_sh    = {rem_reg, quo_reg[MW-1]};
    assign div_trial = div_sh - {1'b0, dvs_reg};
    assign div_fit   = (div_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            if (cmd.div_den)
            begin
                qn_reg  <= quo_reg;
                quo_reg <= MW'(den_mag_reg);
            end
            else
            begin
                dvs_reg <= gx_reg << gk_reg;
                quo_reg <= num_mag_reg;
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_fit ? div_trial[MW-1:0] : div_sh[MW-1:0];
            quo_reg <= {quo_reg[MW-2:0], div_fit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign sts.num_zero = (num_mag_reg == '0);
    assign sts.den_zero = (den_mag_reg == '0);
    assign sts.gcd_done = (gx_reg == gy_reg);
    assign sts.div_last = (cnt_reg == CW'(MW - 1));
    assign sts.out_busy = out_valid_reg && !m_tready;

    // result selection and output register
    logic [MW-1:0] rn_mag;
    logic [MW-1:0] rd_mag;
    logic          rn_neg;
    status_t       rst_code;
    logic [XW-1:0] rn_ext;
    logic [XW-1:0] rd_ext;
    logic [XW-1:0] rn_signed;

    always_comb
    begin
        priority if (sts.num_zero && sts.den_zero)
        begin
            rn_mag   = '0;
            rd_mag   = '0;
            rn_neg   = 1'b0;
            rst_code = ST_INDET;
        end
        else if (sts.num_zero)
        begin
            rn_mag   = '0;
            rd_mag   = MW'(1);
            rn_neg   = 1'b0;
            rst_code = ST_VALID;
        end
        else if (sts.den_zero)
        begin
            rn_mag   = MW'(1);
            rd_mag   = '0;
            rn_neg   = num_neg_reg;
            rst_code = ST_UNDEF;
        end
        else
        begin
            rn_mag   = qn_reg;
            rd_mag   = quo_reg;
            rn_neg   = num_neg_reg != den_neg_reg;
            rst_code = ST_VALID;
        end
        rn_ext    = XW'(rn_mag);
        rd_ext    = XW'(rd_mag);
        rn_signed = rn_neg ? (XW'(0) - rn_ext) : rn_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_num_reg <= rn_signed[NUM_OUT_WIDTH-1:0];
            res_den_reg <= rd_ext[DEN_OUT_WIDTH-1:0];
            res_st_reg  <= rst_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({res_den_reg, res_num_reg});
    assign m_tuser  = res_st_reg;

endmodule

FILE: hdl/rational_alu_gcd_reduce.sv
// Channel | Dir | tdata (low bit up)                   | tuser
// s_*     | in  | a_num, a_den, b_num, b_den           | req_type
// m_*     | out | res_num (33), res_den (31)           | status
//
// One item at a time: load, three multiplies (one shared multiplier), combine,
// classify, binary GCD, then two restoring divisions (numerator, then denominator).
// Zero numerator or zero denominator skips GCD and division.
// rst_n clears the controller and output valid; no clearing pass.
// A stalled result sits in the output register while the next beat is accepted.
`include "rational_alu_gcd_reduce_macros.svh"

module rational_alu_gcd_reduce
#(
    parameter  int OPERAND_WIDTH = 16,
    localparam int IN_TDATA_W    = ((4 * OPERAND_WIDTH + 7) / 8) * 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_TDATA_W-1:0]               s_tdata,   // a_num, a_den, b_num, b_den
    input  logic [rag_pkg::REQ_WIDTH-1:0]       s_tuser,   // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rag_pkg::OUT_TDATA_W-1:0]     m_tdata,   // res_num, res_den
    output logic [rag_pkg::STATUS_WIDTH-1:0]    m_tuser    // status
);
    import rag_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rag_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rag_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    logic [NUM_OUT_WIDTH-1:0] res_num;
    logic [DEN_OUT_WIDTH-1:0] res_den;

    assign res_num = m_tdata[NUM_OUT_WIDTH-1:0];
    assign res_den = m_tdata[NUM_OUT_WIDTH +: DEN_OUT_WIDTH];

    `RAG_ASSERT_NXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready, "second beat taken while busy")
    `RAG_ASSERT_IMP(a_valid_den, clk, rst_n, m_tvalid && m_tuser == ST_VALID, res_den != '0, "zero denominator on valid result")
    `RAG_ASSERT_IMP(a_undef_res, clk, rst_n, m_tvalid && m_tuser == ST_UNDEF, res_den == '0 && (res_num == NUM_OUT_WIDTH'(1) || res_num == {NUM_OUT_WIDTH{1'b1}}), "bad undefined result")

endmodule
